[sv/assert_macros.svh]
// Assertion macros shared by the pending entry table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PET_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define PET_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[sv/pet_pkg.sv]
// Shared types and codes of the pending entry table.
`default_nettype none
package pet_pkg;
	// Most entries one remove request may emit
	localparam int MAX_RESULTS = 32;

	// Operation codes, equal to the action field encoding
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_AGE    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_REFRESH = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_REMOVED = 2'd3;

	localparam logic [5:0] OCC_MAX = 6'd63;

	// Classified command handed from front to back
	typedef struct packed {
		op_t         op;
		logic [7:0]  chain;
		logic [63:0] height;
		logic [63:0] block;
		logic [31:0] now;
		logic [31:0] cutoff;
	} cmd_t;
endpackage
`default_nettype wire

[sv/pet_front.sv]
// Front end: decodes the request beat and computes the aging cutoff.
`default_nettype none
module pet_front (
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  chain_id,
	input  wire logic [63:0] height,
	input  wire logic [63:0] block_id,
	input  wire logic [31:0] now,
	input  wire logic [31:0] max_age,
	output pet_pkg::cmd_t    cmd
);
	// Cutoff saturates at zero
	always_comb begin
		cmd.op     = pet_pkg::op_t'(action);
		cmd.chain  = chain_id;
		cmd.height = height;
		cmd.block  = block_id;
		cmd.now    = now;
		cmd.cutoff = (now > max_age) ? (now - max_age) : 32'd0;
	end
endmodule
`default_nettype wire

[sv/pet_fifo.sv]
// Two-entry command queue between front and back.
`default_nettype none
module pet_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire pet_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output pet_pkg::cmd_t      head_cmd
);
	pet_pkg::cmd_t ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_cmd   = ent_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

[sv/pet_back.sv]
// Back end: table memories, slot scan engine and result register.
`default_nettype none
module pet_back #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire pet_pkg::cmd_t cmd,
	output logic               cmd_pop,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output logic [1:0]         status,
	output logic               has_entry,
	output logic [7:0]         out_chain,
	output logic [63:0]        out_height,
	output logic [63:0]        out_block,
	output logic [31:0]        out_arrival,
	output logic [5:0]         occupancy,
	output logic               last
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DONE,
		S_EMIT,
		S_RESP
	} state_t;

	state_t        state_q;
	pet_pkg::cmd_t cmd_q;

	// Table storage
	logic [7:0]  mem_chain  [TABLE_DEPTH];
	logic [63:0] mem_height [TABLE_DEPTH];
	logic [63:0] mem_block  [TABLE_DEPTH];
	logic [31:0] mem_arr    [TABLE_DEPTH];

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CW-1:0] count_q;

	// Scan pipeline
	logic [CW-1:0] addr_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic [7:0]    rd_chain_s1;
	logic [63:0]   rd_height_s1;
	logic [63:0]   rd_block_s1;
	logic [31:0]   rd_arr_s1;

	// Scan results
	logic          hit_found_q;
	logic [IW-1:0] hit_idx_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;
	logic          best_found_q;
	logic [IW-1:0] best_idx_q;
	logic [7:0]    best_chain_q;
	logic [63:0]   best_height_q;
	logic [63:0]   best_block_q;
	logic [31:0]   best_arr_q;
	logic [CW-1:0] match_q;
	logic [CW-1:0] emit_n_q;
	logic [CW-1:0] emitted_q;
	logic [CW-1:0] final_q;
	logic [1:0]    resp_st_q;

	// Result register
	logic          rsp_valid_q;
	logic [1:0]    status_q;
	logic          has_entry_q;
	logic [7:0]    out_chain_q;
	logic [63:0]   out_height_q;
	logic [63:0]   out_block_q;
	logic [31:0]   out_arr_q;
	logic [5:0]    occ_q;
	logic          last_q;

	logic          out_free;
	logic          rsp_load;
	logic          wr_en;
	logic          wr_all;
	logic [IW-1:0] wr_idx;
	logic          rm_match;
	logic [CW-1:0] cap;

	function automatic logic [5:0] occ_of(input logic [CW-1:0] c);
		return (32'(c) > 32'(pet_pkg::OCC_MAX)) ? pet_pkg::OCC_MAX : 6'(c);
	endfunction

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_load = out_free && ((state_q == S_EMIT) || (state_q == S_RESP));
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;

	// Insert write port
	assign wr_en  = (state_q == S_DONE) && (cmd_q.op == pet_pkg::OP_INSERT) &&
		(hit_found_q || free_found_q);
	assign wr_all = !hit_found_q;
	assign wr_idx = hit_found_q ? hit_idx_q : free_idx_q;

	assign rm_match = valid_q[idx_s1] && (rd_chain_s1 == cmd_q.chain) &&
		(rd_height_s1 <= cmd_q.height);
	assign cap = (32'(match_q) > 32'(pet_pkg::MAX_RESULTS)) ?
		CW'(pet_pkg::MAX_RESULTS) : match_q;

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_arr[wr_idx] <= cmd_q.now;
			if (wr_all) begin
				mem_chain[wr_idx]  <= cmd_q.chain;
				mem_height[wr_idx] <= cmd_q.height;
				mem_block[wr_idx]  <= cmd_q.block;
			end
		end
		rd_chain_s1  <= mem_chain[addr_q[IW-1:0]];
		rd_height_s1 <= mem_height[addr_q[IW-1:0]];
		rd_block_s1  <= mem_block[addr_q[IW-1:0]];
		rd_arr_s1    <= mem_arr[addr_q[IW-1:0]];
	end

	// Control sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= '0;
			valid_q       <= '0;
			count_q       <= '0;
			addr_q        <= '0;
			vld_s1        <= 1'b0;
			idx_s1        <= '0;
			hit_found_q   <= 1'b0;
			hit_idx_q     <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			best_found_q  <= 1'b0;
			best_idx_q    <= '0;
			best_chain_q  <= '0;
			best_height_q <= '0;
			best_block_q  <= '0;
			best_arr_q    <= '0;
			match_q       <= '0;
			emit_n_q      <= '0;
			emitted_q     <= '0;
			final_q       <= '0;
			resp_st_q     <= pet_pkg::ST_OK;
			rsp_valid_q   <= 1'b0;
			status_q      <= pet_pkg::ST_OK;
			has_entry_q   <= 1'b0;
			out_chain_q   <= '0;
			out_height_q  <= '0;
			out_block_q   <= '0;
			out_arr_q     <= '0;
			occ_q         <= '0;
			last_q        <= 1'b0;
		end else begin
			// Result valid: load a new beat or drop the one taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q        <= cmd;
						addr_q       <= '0;
						vld_s1       <= 1'b0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						best_found_q <= 1'b0;
						match_q      <= '0;
						emitted_q    <= '0;
						resp_st_q    <= pet_pkg::ST_OK;
						state_q      <= (cmd.op == pet_pkg::OP_NOP) ? S_RESP : S_SCAN;
					end
				end
				S_SCAN: begin
					// Issue one slot read a cycle, check the slot read last cycle
					vld_s1 <= (addr_q != CW'(TABLE_DEPTH));
					idx_s1 <= addr_q[IW-1:0];
					if (addr_q != CW'(TABLE_DEPTH)) begin
						addr_q <= addr_q + 1'b1;
					end
					if (vld_s1) begin
						case (cmd_q.op)
							pet_pkg::OP_INSERT: begin
								if (valid_q[idx_s1]) begin
									if (!hit_found_q && rd_block_s1 == cmd_q.block) begin
										hit_found_q <= 1'b1;
										hit_idx_q   <= idx_s1;
									end
								end else if (!free_found_q) begin
									free_found_q <= 1'b1;
									free_idx_q   <= idx_s1;
								end
							end
							pet_pkg::OP_AGE: begin
								if (valid_q[idx_s1] && rd_arr_s1 < cmd_q.cutoff) begin
									valid_q[idx_s1] <= 1'b0;
									count_q         <= count_q - 1'b1;
								end
							end
							pet_pkg::OP_REMOVE: begin
								if (rm_match) begin
									match_q <= match_q + 1'b1;
									if (!best_found_q || rd_height_s1 < best_height_q) begin
										best_found_q  <= 1'b1;
										best_idx_q    <= idx_s1;
										best_chain_q  <= rd_chain_s1;
										best_height_q <= rd_height_s1;
										best_block_q  <= rd_block_s1;
										best_arr_q    <= rd_arr_s1;
									end
								end
							end
							default: begin
							end
						endcase
						if (idx_s1 == IW'(TABLE_DEPTH - 1)) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					case (cmd_q.op)
						pet_pkg::OP_INSERT: begin
							state_q <= S_RESP;
							if (hit_found_q) begin
								resp_st_q <= pet_pkg::ST_REFRESH;
							end else if (!free_found_q) begin
								resp_st_q <= pet_pkg::ST_FULL;
							end else begin
								valid_q[free_idx_q] <= 1'b1;
								count_q             <= count_q + 1'b1;
							end
						end
						pet_pkg::OP_REMOVE: begin
							if (emitted_q == '0) begin
								if (!best_found_q) begin
									state_q <= S_RESP;
								end else begin
									emit_n_q <= cap;
									final_q  <= count_q - cap;
									state_q  <= S_EMIT;
								end
							end else begin
								state_q <= S_EMIT;
							end
						end
						default: state_q <= S_RESP;
					endcase
				end
				S_EMIT: begin
					if (out_free) begin
						status_q             <= pet_pkg::ST_REMOVED;
						has_entry_q          <= 1'b1;
						out_chain_q          <= best_chain_q;
						out_height_q         <= best_height_q;
						out_block_q          <= best_block_q;
						out_arr_q            <= best_arr_q;
						occ_q                <= occ_of(final_q);
						last_q               <= (CW'(emitted_q + 1'b1) == emit_n_q);
						valid_q[best_idx_q]  <= 1'b0;
						count_q              <= count_q - 1'b1;
						emitted_q            <= emitted_q + 1'b1;
						addr_q               <= '0;
						vld_s1               <= 1'b0;
						best_found_q         <= 1'b0;
						match_q              <= '0;
						state_q <= (CW'(emitted_q + 1'b1) == emit_n_q) ? S_IDLE : S_SCAN;
					end
				end
				S_RESP: begin
					if (out_free) begin
						status_q     <= resp_st_q;
						has_entry_q  <= 1'b0;
						out_chain_q  <= '0;
						out_height_q <= '0;
						out_block_q  <= '0;
						out_arr_q    <= '0;
						occ_q        <= occ_of(count_q);
						last_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign has_entry   = has_entry_q;
	assign out_chain   = out_chain_q;
	assign out_height  = out_height_q;
	assign out_block   = out_block_q;
	assign out_arrival = out_arr_q;
	assign occupancy   = occ_q;
	assign last        = last_q;
endmodule
`default_nettype wire

[sv/pending_entry_table_with_aging.sv]
// Insert and age run one full slot scan of the table before the result register is loaded.
// Remove runs a full slot scan for each emitted entry: each entry needs its own scan.
// Throughput: one request at a time; the slot scan reads one table entry per cycle.
// A two-entry queue lets requests be taken while the back end is busy.
// Reset: asynchronous, active low; clears all slot valid bits, occupancy and the queue.
`default_nettype none
`include "assert_macros.svh"
module pending_entry_table_with_aging #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  chain_id,
	input  wire logic [63:0] height,
	input  wire logic [63:0] block_id,
	input  wire logic [31:0] now,
	input  wire logic [31:0] max_age,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [1:0]       status,
	output logic             has_entry,
	output logic [7:0]       out_chain,
	output logic [63:0]      out_height,
	output logic [63:0]      out_block,
	output logic [31:0]      out_arrival,
	output logic [5:0]       occupancy,
	output logic             last
);
	pet_pkg::cmd_t front_cmd;
	pet_pkg::cmd_t head_cmd;
	logic          q_full;
	logic          q_valid;
	logic          q_pop;

	// Decode
	pet_front u_front (
		.action   (action),
		.chain_id (chain_id),
		.height   (height),
		.block_id (block_id),
		.now      (now),
		.max_age  (max_age),
		.cmd      (front_cmd)
	);

	// Command queue
	pet_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (req_valid && !q_full),
		.push_cmd   (front_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_cmd   (head_cmd)
	);

	assign req_stall = q_full;

	// Table engine
	pet_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_valid),
		.cmd         (head_cmd),
		.cmd_pop     (q_pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.has_entry   (has_entry),
		.out_chain   (out_chain),
		.out_height  (out_height),
		.out_block   (out_block),
		.out_arrival (out_arrival),
		.occupancy   (occupancy),
		.last        (last)
	);

	// Checks
	`PET_ASSERT(a_entry_status, rsp_valid && has_entry |-> status == pet_pkg::ST_REMOVED, "entry beat without removed status")
	`PET_ASSERT(a_plain_last, rsp_valid && !has_entry |-> last, "plain beat not marked last")
	`PET_NEVER(a_occ_range, rsp_valid && (32'(occupancy) > TABLE_DEPTH), "occupancy above table depth")
endmodule
`default_nettype wire
